[hw/rtl/assert_macros.svh]
// Assertion macros used by the controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/itac_pkg.sv]
// Types, constants and helpers for the integer to ASCII converter.
package itac_pkg;

    localparam logic [1:0] FMT_UNSIGNED = 2'd0;
    localparam logic [1:0] FMT_SIGNED   = 2'd1;
    localparam logic [1:0] FMT_HEX      = 2'd2;

    localparam logic [6:0] ASCII_MINUS  = 7'd45;
    localparam logic [6:0] ASCII_ZERO   = 7'd48;
    localparam logic [6:0] ASCII_A_LOW  = 7'd97;

    // ceil(2^35 / 10): (x * RECIP_10) >> 35 == x / 10 for every 32-bit x
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    localparam int          DIGIT_SLOTS = 10;
    localparam logic [3:0]  LAST_SLOT   = 4'd9;

    typedef struct packed {
        logic load;
        logic step;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic conv_done;
        logic idx_zero;
        logic out_free;
    } t_status;

    function automatic logic [6:0] digit_char(input logic [3:0] d);
        logic [6:0] base;
        base = (d > 4'd9) ? (ASCII_A_LOW - 7'd10) : ASCII_ZERO;
        return base + {3'b000, d};
    endfunction

endpackage

[hw/rtl/itac_datapath.sv]
// Datapath: digit extraction, digit store and output register.
module itac_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itac_pkg::t_cmd       i_cmd,
    output itac_pkg::t_status    o_status,
    input  logic [31:0]          i_value,
    input  logic [1:0]           i_format,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [6:0]           o_char_code,
    output logic                 o_last
);
    import itac_pkg::*;

    logic [31:0] r_num;
    logic        r_hex;
    logic        r_neg;
    logic [3:0]  r_count;
    logic [3:0]  r_idx;
    logic [3:0]  r_digits [DIGIT_SLOTS];
    logic        r_out_valid;
    logic [6:0]  r_out_char;
    logic        r_out_last;

    logic [63:0] w_prod;
    logic [31:0] w_quot;
    logic [35:0] w_quot_x10;
    logic [3:0]  w_rem;
    logic        w_neg_in;

    assign w_neg_in   = (i_format == FMT_SIGNED) && i_value[31];

    assign w_prod     = {32'b0, r_num} * {32'b0, RECIP_10};
    assign w_quot_x10 = {1'b0, w_quot, 3'b000} + {3'b000, w_quot, 1'b0};

    always_comb begin
        if (r_hex) begin
            w_quot = {4'b0000, r_num[31:4]};
            w_rem  = r_num[3:0];
        end else begin
            w_quot = {3'b000, w_prod[63:RECIP_SHIFT]};
            // remainder is below 10, so the low nibble of the difference is exact
            w_rem  = r_num[3:0] - w_quot_x10[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num   <= w_neg_in ? (~i_value + 32'd1) : i_value;
            r_hex   <= (i_format == FMT_HEX);
            r_neg   <= w_neg_in;
            r_count <= 4'd0;
        end else if (i_cmd.step) begin
            r_num             <= w_quot;
            r_digits[r_count] <= w_rem;
            r_idx             <= r_count;
            r_count           <= r_count + 4'd1;
        end else if (i_cmd.emit_digit) begin
            r_idx <= r_idx - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_char <= ASCII_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= digit_char(r_digits[r_idx]);
            r_out_last <= (r_idx == 4'd0);
        end
    end

    assign o_status.neg       = r_neg;
    assign o_status.conv_done = (w_quot == 32'd0) || (r_count == LAST_SLOT);
    assign o_status.idx_zero  = (r_idx == 4'd0);
    assign o_status.out_free  = !r_out_valid || !i_stall;

    assign o_valid     = r_out_valid;
    assign o_char_code = r_out_char;
    assign o_last      = r_out_last;

endmodule

[hw/rtl/itac_ctrl.sv]
// Controller: sequences load, digit extraction and character emission.
module itac_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_busy,
    input  itac_pkg::t_status    i_status,
    output itac_pkg::t_cmd       o_cmd
);
    import itac_pkg::*;
    `include "assert_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CONV;
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                if (i_status.conv_done) begin
                    n_state = i_status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sign = 1'b1;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_digit = 1'b1;
                    if (i_status.idx_zero) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    `ASSERT_IMPLY(a_one_cmd, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd), "more than one command")
    `ASSERT_IMPLY(a_emit_free, i_clk, i_rst_n, o_cmd.emit_sign || o_cmd.emit_digit, i_status.out_free, "emit into occupied output")
    `ASSERT_NEXT(a_sign_then_digits, i_clk, i_rst_n, o_cmd.emit_sign, r_state == ST_EMIT, "sign not followed by digits")
    `ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, o_cmd.load, o_busy, "load without busy")

endmodule

[hw/rtl/integer_to_ascii_converter_top.sv]
// Top level of the integer to ASCII converter.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------
//  input    | i_valid / o_stall   | i_value[31:0], i_format[1:0]
//  output   | o_valid / i_stall   | o_char_code[6:0], o_last
//
// A transaction with N digits is a load, N steps of digit extraction (one divide by
// the radix per cycle, by the reciprocal multiplier for decimal and by a shift for hex)
// and then the characters out, the sign first if any, one per cycle while not stalled.
// o_stall is high from acceptance until the last character enters the output register.
// Synchronous active-low reset clears the controller and the output valid.
// Output stalls hold the output register and pause emission.
module integer_to_ascii_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_value,
    input  logic [1:0]  i_format,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [6:0]  o_char_code,
    output logic        o_last
);
    import itac_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy;

    itac_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_busy   (w_busy),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    itac_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_value     (i_value),
        .i_format    (i_format),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    assign o_stall = w_busy;

endmodule

[test/integer_to_ascii_converter_top_tb.sv]
// Self-checking testbench for the integer to ASCII converter, checked per character.
module integer_to_ascii_converter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itac_pkg::*;

    // format code 3 is not defined and falls back to unsigned decimal
    localparam logic [1:0] FMT_SPARE     = 2'd3;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         MAX_DIGITS    = 10;
    localparam int         RX_HOLD_LEN   = 250;
    localparam int         DRAIN_CYCLES  = 30;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  fmt;
    } t_word_item;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_text_char;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic [31:0] i_value     = '0;
    logic [1:0]  i_format    = FMT_UNSIGNED;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic [6:0]  o_char_code;
    logic        o_last;

    t_word_item  pending_words[$];
    t_text_char  expected_text[$];

    int          fail_count   = 0;
    int          tx_gap       = 0;
    int          rx_wait      = 0;
    int          rx_hold_left = 0;
    int          idle_cycles  = 0;
    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;

    integer_to_ascii_converter_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value     (i_value),
        .i_format    (i_format),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Expected text of one word, most significant character first.
    function automatic void predict_text(logic [31:0] word, logic [1:0] fmt);
        logic [31:0] mag;
        logic [31:0] radix;
        logic [3:0]  digit;
        logic [3:0]  digits[$];
        logic        negative;
        t_text_char  ch;
        radix    = (fmt == FMT_HEX) ? 32'd16 : 32'd10;
        negative = (fmt == FMT_SIGNED) && word[31];
        mag      = negative ? (~word + 32'd1) : word;
        do begin
            digit = 4'(mag % radix);
            digits.push_front(digit);
            mag = mag / radix;
        end while (mag != 0 && digits.size() < MAX_DIGITS);
        if (negative) begin
            ch.code = ASCII_MINUS;
            ch.last = 1'b0;
            expected_text.push_back(ch);
        end
        foreach (digits[i]) begin
            ch.code = (digits[i] > 4'd9) ? ASCII_A_LOW + 7'(digits[i]) - 7'd10
                                          : ASCII_ZERO + 7'(digits[i]);
            ch.last = (i == digits.size() - 1);
            expected_text.push_back(ch);
        end
    endfunction

    task automatic add_word(logic [31:0] word, logic [1:0] fmt);
        t_word_item item;
        item.word = word;
        item.fmt  = fmt;
        pending_words.push_back(item);
    endtask

    function automatic logic [31:0] random_word();
        logic [31:0] w;
        case ($urandom_range(0, 4))
            0: w = $urandom;
            1: w = $urandom_range(0, 20);
            2: w = $urandom >> $urandom_range(0, 31);
            3: w = ~($urandom >> $urandom_range(1, 31));    // small negatives
            default: w = {$urandom_range(0, 1) == 1, 31'($urandom)};
        endcase
        return w;
    endfunction

    function automatic logic [1:0] random_format();
        return ($urandom_range(0, 9) == 0) ? FMT_SPARE : 2'($urandom_range(0, 2));
    endfunction

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_words.size() != 0 || i_valid || expected_text.size() != 0);
    endtask

    // Sender: predicts on acceptance, then offers the next word after its gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_text(i_value, i_format);
            end
            if (!i_valid || !o_stall) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_value  <= pending_words[0].word;
                    i_format <= pending_words[0].fmt;
                    i_valid  <= 1'b1;
                    void'(pending_words.pop_front());
                    tx_gap = tx_idle_on ? $urandom_range(0, 14) : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each character transaction and draws its stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_text.size() == 0) begin
                    $error("unexpected character: char_code %0d last %0b", o_char_code, o_last);
                    fail_count++;
                end else begin
                    if (o_char_code !== expected_text[0].code) begin
                        $error("char_code: expected %0d, got %0d",
                               expected_text[0].code, o_char_code);
                        fail_count++;
                    end
                    if (o_last !== expected_text[0].last) begin
                        $error("last: expected %0b, got %0b", expected_text[0].last, o_last);
                        fail_count++;
                    end
                    void'(expected_text.pop_front());
                end
                rx_wait = rx_idle_on ? $urandom_range(0, 14) : 0;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
            end
            i_stall <= (rx_wait > 0) || (rx_hold_left > 0);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero, extremes, sign boundary, digit and radix boundaries
        add_word(32'd0, FMT_UNSIGNED);
        add_word(32'd0, FMT_SIGNED);
        add_word(32'd0, FMT_HEX);
        add_word(32'd0, FMT_SPARE);
        add_word(32'hFFFF_FFFF, FMT_UNSIGNED);
        add_word(32'hFFFF_FFFF, FMT_SIGNED);
        add_word(32'hFFFF_FFFF, FMT_HEX);
        add_word(32'hFFFF_FFFF, FMT_SPARE);
        add_word(32'h8000_0000, FMT_UNSIGNED);
        add_word(32'h8000_0000, FMT_SIGNED);
        add_word(32'h8000_0000, FMT_HEX);
        add_word(32'h7FFF_FFFF, FMT_SIGNED);
        add_word(32'h7FFF_FFFF, FMT_HEX);
        add_word(32'd1, FMT_SIGNED);
        add_word(32'd9, FMT_UNSIGNED);
        add_word(32'd10, FMT_UNSIGNED);
        add_word(32'd15, FMT_HEX);
        add_word(32'd16, FMT_HEX);
        add_word(32'hDEAD_BEEF, FMT_HEX);
        add_word(32'd1_000_000_000, FMT_SIGNED);
        add_word(32'hFFFF_FFF6, FMT_SIGNED);
        add_word(32'd12345, FMT_SPARE);
        wait_drained();

        // back to back, no idling on either side
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (40) add_word(random_word(), random_format());
        wait_drained();

        // receiver holds off while the sender keeps offering
        rx_idle_on   = 1'b1;
        rx_hold_left = RX_HOLD_LEN;
        repeat (40) add_word(random_word(), random_format());
        wait_drained();

        tx_idle_on = 1'b1;
        repeat (48) add_word(random_word(), random_format());
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_text.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[integer_to_ascii_converter_top.f]
+incdir+hw/rtl
hw/rtl/itac_pkg.sv
hw/rtl/itac_datapath.sv
hw/rtl/itac_ctrl.sv
hw/rtl/integer_to_ascii_converter_top.sv
test/integer_to_ascii_converter_top_tb.sv
